@@ sv/aes128_block_encrypt_top_macros.svh @@
// ----------------------------------------------------------------------------
// aes128_block_encrypt_top_macros
// Assertion macros for the AES-128 block encryptor.
// ----------------------------------------------------------------------------
`ifndef AES128_BLOCK_ENCRYPT_TOP_MACROS_SVH
`define AES128_BLOCK_ENCRYPT_TOP_MACROS_SVH

// Check that a condition implies a property on the next clock edge.
`define AES_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

// Check that a condition implies a property on the same clock edge.
`define AES_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

@@ sv/aes_pkg.sv @@
// ----------------------------------------------------------------------------
// aes_pkg
// Shared constants, S-box, round constants and byte helpers.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int unsigned BlockW     = 128;
    localparam int unsigned DigitW     = 8;
    localparam int unsigned NumBytes   = BlockW / DigitW;
    localparam int unsigned ByteIdxW   = $clog2(NumBytes);
    localparam int unsigned RoundW     = 6;
    localparam int unsigned PassW      = 16;
    localparam int unsigned RconIdxW   = 5;
    localparam logic [7:0]  ReducePoly = 8'h1b;
    localparam logic [RoundW-1:0] RoundReset = 6'd10;
    localparam logic [PassW-1:0]  PassReset  = 16'd1;

    // register indexes
    localparam logic [1:0] RegKeyHigh = 2'd0;
    localparam logic [1:0] RegKeyLow  = 2'd1;
    localparam logic [1:0] RegRounds  = 2'd2;
    localparam logic [1:0] RegPasses  = 2'd3;

    // round engine phases
    localparam logic [2:0] PhIdle  = 3'd0;
    localparam logic [2:0] PhSub   = 3'd1;
    localparam logic [2:0] PhMix   = 3'd2;
    localparam logic [2:0] PhKey   = 3'd3;
    localparam logic [2:0] PhAdd   = 3'd4;
    localparam logic [2:0] PhDone  = 3'd5;

    typedef logic [BlockW-1:0] block_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } eng_stat_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] tab [256];
        tab = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return tab[a];
    endfunction

    function automatic logic [7:0] rcon(input logic [RconIdxW-1:0] i);
        logic [7:0] tab [32];
        tab = '{8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36,
                8'h6c,8'hd8,8'hab,8'h4d,8'h9a,8'h2f,8'h5e,8'hbc,8'h63,8'hc6,
                8'h97,8'h35,8'h6a,8'hd4,8'hb3,8'h7d,8'hfa,8'hef,8'hc5,8'h91,
                8'h39,8'h72};
        return tab[i];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? ReducePoly : 8'h00);
    endfunction

    // byte n of a block in standard order (byte 0 most significant)
    function automatic logic [7:0] get_byte(input block_t b, input logic [ByteIdxW-1:0] n);
        return b[BlockW-1-DigitW*n -: DigitW];
    endfunction

endpackage

@@ sv/aes_key_sched.sv @@
// ----------------------------------------------------------------------------
// aes_key_sched
// Round key register with a byte-serial next-key step (one byte per cycle when step_en is set).
// ----------------------------------------------------------------------------
module aes_key_sched (
    input  logic                           clk,
    input  logic                           load,
    input  aes_pkg::block_t                cipher_key,
    input  logic                           step_en,
    input  logic [aes_pkg::ByteIdxW-1:0]   step_idx,
    input  logic [aes_pkg::RconIdxW-1:0]   rcon_idx,
    output aes_pkg::block_t                round_key
);
    aes_pkg::block_t rk_reg;
    aes_pkg::block_t rk_next;
    logic [31:0]     temp_reg;
    logic [31:0]     temp_next;
    logic [7:0]      t_byte;
    logic [7:0]      prev_byte;
    logic [7:0]      new_byte;

    // byte-serial: byte i uses t[i] for i<4, else new byte i-4 (already rolled in)
    always_comb
    begin
        temp_next = temp_reg;
        if (step_idx == '0)
        begin
            temp_next = {aes_pkg::sbox(aes_pkg::get_byte(rk_reg, 4'd13))
                             ^ aes_pkg::rcon(rcon_idx),
                         aes_pkg::sbox(aes_pkg::get_byte(rk_reg, 4'd14)),
                         aes_pkg::sbox(aes_pkg::get_byte(rk_reg, 4'd15)),
                         aes_pkg::sbox(aes_pkg::get_byte(rk_reg, 4'd12))};
        end
        // rotating register: byte 0 of the head is next to process
        t_byte    = temp_next[31:24];
        prev_byte = rk_reg[31:24];
        new_byte  = rk_reg[127:120] ^ ((step_idx < 4'd4) ? t_byte : prev_byte);
        rk_next   = {rk_reg[119:0], new_byte};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rk_reg <= cipher_key;
        end
        else if (step_en)
        begin
            rk_reg   <= rk_next;
            temp_reg <= {temp_next[23:0], temp_next[31:24]};
        end
    end

    assign round_key = rk_reg;
endmodule

@@ sv/aes_round_eng.sv @@
// ----------------------------------------------------------------------------
// aes_round_eng
// Byte-serial AES state engine: SubBytes/ShiftRows, MixColumns and
// AddRoundKey, each sweeping the state one byte per cycle.
// ----------------------------------------------------------------------------
module aes_round_eng (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  aes_pkg::block_t          plain,
    input  aes_pkg::block_t          cipher_key,
    input  logic [aes_pkg::RoundW-1:0] rounds_cfg,
    input  logic [aes_pkg::PassW-1:0]  passes_cfg,
    output aes_pkg::eng_stat_t       stat,
    output aes_pkg::block_t          result
);
    logic [2:0]                     ph_reg, ph_next;
    logic [aes_pkg::ByteIdxW-1:0]   cnt_reg, cnt_next;
    logic [aes_pkg::RoundW-1:0]     rnd_reg, rnd_next;
    logic [aes_pkg::RoundW-1:0]     last_reg;
    logic [aes_pkg::PassW-1:0]      pass_reg, pass_next;
    logic [aes_pkg::RconIdxW-1:0]   ridx_reg, ridx_next;
    aes_pkg::block_t                st_reg, st_next;
    aes_pkg::block_t                snap_reg;
    aes_pkg::block_t                plain_reg;
    aes_pkg::block_t                rk;
    logic                           key_load;
    logic                           key_step;
    logic [aes_pkg::ByteIdxW-1:0]   src;
    logic [1:0]                     row;
    logic [1:0]                     col;
    logic [7:0]                     a0, a1, a2, a3, all, mb;
    logic [7:0]                     nb;

    aes_key_sched u_key (
        .clk        (clk),
        .load       (key_load),
        .cipher_key (cipher_key),
        .step_en    (key_step),
        .step_idx   (cnt_reg),
        .rcon_idx   (ridx_reg),
        .round_key  (rk)
    );

    always_comb
    begin
        row = cnt_reg[1:0];
        col = cnt_reg[3:2];
        src = {col + row, row};
        a0  = aes_pkg::get_byte(snap_reg, {col, 2'd0});
        a1  = aes_pkg::get_byte(snap_reg, {col, 2'd1});
        a2  = aes_pkg::get_byte(snap_reg, {col, 2'd2});
        a3  = aes_pkg::get_byte(snap_reg, {col, 2'd3});
        all = a0 ^ a1 ^ a2 ^ a3;
        unique case (row)
            2'd0: mb = a0 ^ all ^ aes_pkg::xtime(a0 ^ a1);
            2'd1: mb = a1 ^ all ^ aes_pkg::xtime(a1 ^ a2);
            2'd2: mb = a2 ^ all ^ aes_pkg::xtime(a2 ^ a3);
            default: mb = a3 ^ all ^ aes_pkg::xtime(a3 ^ a0);
        endcase
        nb = 8'h00;
        unique case (ph_reg)
            aes_pkg::PhSub: nb = aes_pkg::sbox(aes_pkg::get_byte(snap_reg, src));
            aes_pkg::PhMix: nb = mb;
            aes_pkg::PhAdd: nb = st_reg[127:120] ^ aes_pkg::get_byte(rk, cnt_reg);
            default:        nb = st_reg[127:120];
        endcase
    end

    always_comb
    begin
        ph_next   = ph_reg;
        cnt_next  = cnt_reg;
        rnd_next  = rnd_reg;
        pass_next = pass_reg;
        ridx_next = ridx_reg;
        st_next   = st_reg;
        key_load  = 1'b0;
        key_step  = 1'b0;
        unique case (ph_reg)
            aes_pkg::PhIdle:
            begin
                if (start)
                begin
                    st_next   = plain;
                    cnt_next  = '0;
                    rnd_next  = '0;
                    pass_next = '0;
                    ridx_next = '0;
                    key_load  = 1'b1;
                    ph_next   = (passes_cfg == '0) ? aes_pkg::PhDone : aes_pkg::PhAdd;
                end
            end
            aes_pkg::PhSub, aes_pkg::PhMix:
            begin
                st_next  = {st_reg[119:0], nb};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    ph_next = (ph_reg == aes_pkg::PhSub && rnd_reg != last_reg)
                              ? aes_pkg::PhMix : aes_pkg::PhKey;
                end
            end
            aes_pkg::PhKey:
            begin
                key_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    ridx_next = ridx_reg + 1'b1;
                    ph_next   = aes_pkg::PhAdd;
                end
            end
            aes_pkg::PhAdd:
            begin
                st_next  = {st_reg[119:0], nb};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    if (rnd_reg != last_reg)
                    begin
                        rnd_next = rnd_reg + 1'b1;
                        ph_next  = aes_pkg::PhSub;
                    end
                    else if (pass_reg + 1'b1 == passes_cfg)
                    begin
                        ph_next = aes_pkg::PhDone;
                    end
                    else
                    begin
                        pass_next = pass_reg + 1'b1;
                        rnd_next  = '0;
                        ridx_next = '0;
                        key_load  = 1'b1;
                        st_next   = {st_reg[119:0], nb} ^ plain_reg;
                    end
                end
            end
            aes_pkg::PhDone:
            begin
                ph_next = aes_pkg::PhIdle;
            end
            default:
            begin
                ph_next = aes_pkg::PhIdle;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= aes_pkg::PhIdle;
        end
        else
        begin
            ph_reg <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        rnd_reg  <= rnd_next;
        pass_reg <= pass_next;
        ridx_reg <= ridx_next;
        st_reg   <= st_next;
        if (ph_reg == aes_pkg::PhIdle && start)
        begin
            plain_reg <= plain;
            // a zero round count still runs the final round
            last_reg  <= (rounds_cfg == '0) ? aes_pkg::RoundW'(1) : rounds_cfg;
        end
        // take a snapshot at the start of every byte sweep; the sweeps that permute or mix read it
        if (cnt_next == '0)
        begin
            snap_reg <= st_next;
        end
    end

    assign stat.start = start && (ph_reg == aes_pkg::PhIdle);
    assign stat.busy  = (ph_reg != aes_pkg::PhIdle);
    assign stat.done  = (ph_reg == aes_pkg::PhDone);
    assign result     = st_reg;
endmodule

@@ sv/aes128_block_encrypt_top.sv @@
// ----------------------------------------------------------------------------
// aes128_block_encrypt_top
// AES-128 encryptor, byte-serial, configurable rounds and chained passes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one 128-bit plaintext block per transfer, tdata = {plain_low,
//   plain_high}. m_axis: one ciphertext block per transfer, same packing.
//   APB: key_high at 0x00, key_low at 0x08, round_count at 0x10,
//   chain_passes at 0x18. Write only while the block is idle.
// Operation: each pass opens with an AddRoundKey sweep of the cipher key; each
//   round then steps one byte per cycle through SubBytes/ShiftRows over the
//   16-byte state, MixColumns (not in the final round), a key step and
//   AddRoundKey. Each further pass starts from the last result XORed with the
//   plaintext. The finished block is held in the output register. One block
//   is in flight at a time; a zero pass count presents the plaintext
//   unchanged.
// Reset: the engine phase and output valid clear, registers return to key 0, 10 rounds, 1 pass.
// Stall: the result waits in the output register; s_axis tready stays low
//   until the result transfer completes.
// ----------------------------------------------------------------------------
`include "aes128_block_encrypt_top_macros.svh"

module aes128_block_encrypt_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,   // plain_high [63:0], plain_low [127:64]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // cipher_high [63:0], cipher_low [127:64]
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);
    logic [63:0]                  key_high_reg;
    logic [63:0]                  key_low_reg;
    logic [aes_pkg::RoundW-1:0]   rounds_reg;
    logic [aes_pkg::PassW-1:0]    passes_reg;
    logic                         out_valid_reg;
    aes_pkg::block_t              out_data_reg;
    aes_pkg::eng_stat_t           stat;
    aes_pkg::block_t              result;
    logic                         wr_en;
    logic [1:0]                   reg_idx;
    logic                         accept_in;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:3];

    // hold off new input while the engine runs or a result waits
    assign s_axis_tready = !stat.busy && !out_valid_reg;
    assign accept_in     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            rounds_reg   <= aes_pkg::RoundReset;
            passes_reg   <= aes_pkg::PassReset;
        end
        else if (wr_en && paddr[2:0] == 3'd0)
        begin
            unique case (reg_idx)
                aes_pkg::RegKeyHigh: key_high_reg <= pwdata;
                aes_pkg::RegKeyLow:  key_low_reg  <= pwdata;
                aes_pkg::RegRounds:  rounds_reg   <= pwdata[aes_pkg::RoundW-1:0];
                default:             passes_reg   <= pwdata[aes_pkg::PassW-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            aes_pkg::RegKeyHigh: prdata = key_high_reg;
            aes_pkg::RegKeyLow:  prdata = key_low_reg;
            aes_pkg::RegRounds:  prdata = {58'd0, rounds_reg};
            default:             prdata = {48'd0, passes_reg};
        endcase
    end

    // the engine works on the block in standard byte order, byte 0 on top
    aes_round_eng u_eng (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept_in),
        .plain      ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
        .cipher_key ({key_high_reg, key_low_reg}),
        .rounds_cfg (rounds_reg),
        .passes_cfg (passes_reg),
        .stat       (stat),
        .result     (result)
    );

    // capture the finished block; drop valid once the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stat.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg[63:0], out_data_reg[127:64]};

    `AES_ASSERT_NOW(a_no_accept_busy, clk, rst_n, stat.busy, !s_axis_tready,
        "input accepted while engine busy")
    `AES_ASSERT_NEXT(a_done_sets_valid, clk, rst_n, stat.done, m_axis_tvalid,
        "finished block not presented")
    `AES_ASSERT_NOW(a_done_no_pending, clk, rst_n, stat.done, !out_valid_reg,
        "result overwritten before transfer")
endmodule
